// File: design/bps_pkg.sv
// shared types and codes for the bus poll scheduler
package bps_pkg;

  // fixed field widths
  localparam int SLAVE_W = 8;
  localparam int WORD_W  = 16;
  localparam int POS_W   = 6;
  localparam int MASK_W  = 51;
  localparam int CFG_W   = 8;

  // item actions
  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_NEXT = 1'b1
  } action_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PUSH_OK = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_ISSUED  = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic {
    REG_HIGHEST_SLAVE = 1'b0,
    REG_READ_DIR      = 1'b1
  } reg_index_t;

  // slot limits
  localparam logic [1:0] MSG_FIRST  = 2'd1;
  localparam logic [1:0] MSG_LAST   = 2'd3;
  localparam logic [2:0] INFO_FIRST = 3'd1;
  localparam logic [2:0] INFO_LAST  = 3'd4;
  localparam logic [7:0] POLL_COUNT = 8'd2;

  typedef struct packed {
    action_t             action;
    logic [SLAVE_W-1:0]  cmd_slave;
    logic [7:0]          cmd_direction;
    logic [7:0]          cmd_count;
    logic [7:0]          cmd_start;
    logic [WORD_W-1:0]   cmd_word0;
    logic [WORD_W-1:0]   cmd_word1;
    logic [MASK_W-1:0]   detected_mask;
  } in_item_t;

  typedef struct packed {
    kind_t               kind;
    logic [SLAVE_W-1:0]  out_slave;
    logic [7:0]          out_direction;
    logic [7:0]          out_count;
    logic [7:0]          out_start;
    logic [WORD_W-1:0]   out_word0;
    logic [WORD_W-1:0]   out_word1;
    logic                from_mailbox;
  } out_item_t;

  // one mailbox entry
  typedef struct packed {
    logic [SLAVE_W-1:0]  slave;
    logic [7:0]          direction;
    logic [7:0]          count;
    logic [7:0]          start;
    logic [WORD_W-1:0]   word0;
    logic [WORD_W-1:0]   word1;
  } mb_entry_t;

  // poll position with its slot counters
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [1:0]       msg;
    logic [2:0]       info;
  } poll_state_t;

endpackage

// File: design/bps_advance.sv
// position step unit: one poll position step with slot wrap
module bps_advance
  import bps_pkg::*;
(
  input  poll_state_t      cur,
  input  logic [POS_W-1:0] eff_highest,
  output poll_state_t      nxt
);

  logic [POS_W:0] pos_inc;
  logic           wrap;

  // increment and compare against the highest polled slave
  assign pos_inc = {1'b0, cur.pos} + 1'b1;
  assign wrap    = pos_inc > {1'b0, eff_highest};

  // wrap steps message slot, its wrap steps info slot
  always_comb begin
    nxt = cur;
    if (wrap) begin
      nxt.pos = '0;
      if (cur.msg >= MSG_LAST) begin
        nxt.msg = MSG_FIRST;
        nxt.info = (cur.info >= INFO_LAST) ? INFO_FIRST : cur.info + 1'b1;
      end else begin
        nxt.msg = cur.msg + 1'b1;
      end
    end else begin
      nxt.pos = pos_inc[POS_W-1:0];
    end
  end

endmodule

// File: design/bus_poll_scheduler_with_mailbox.sv
// bus poll scheduler top level with ring mailbox and scan sequencer
//
//   channel   handshake         payload          notes
//   input     start / busy      item (in_item_t)  taken when start & !busy
//   result    done strobe       result            one cycle, cannot be held off
//   config    cfg_we            cfg_index/data    written at once; user writes idle only, not enforced
//
// a push leaves busy low; its word follows in the next cycle.
// a next item sets busy, then the scan takes position steps to a detected slave
// (at most MAX_SLAVES) and decides; the single position step unit makes each step.
// reset restarts pointers, position and slots; mailbox contents stay undefined
// and need no clearing pass. the receiver cannot stall, so done is one cycle.
module bus_poll_scheduler_with_mailbox
  import bps_pkg::*;
#(
  parameter int MAILBOX_DEPTH = 128,
  parameter int MAX_SLAVES    = 50
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_item_t         item,
  input  logic             cfg_we,
  input  reg_index_t       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             done,
  output out_item_t        result
);

  localparam int PTR_W = (MAILBOX_DEPTH > 1) ? $clog2(MAILBOX_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAILBOX_DEPTH - 1);
  localparam logic [POS_W-1:0] MAX_POS  = POS_W'(MAX_SLAVES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  state_t            state;
  logic [POS_W-1:0]  highest_slave;
  logic [7:0]        read_direction_code;
  logic [PTR_W-1:0]  write_pointer;
  logic [PTR_W-1:0]  read_pointer;
  poll_state_t       poll;
  poll_state_t       poll_step;
  logic [MASK_W-1:0] mask;
  logic [POS_W-1:0]  eff_highest;
  logic [PTR_W-1:0]  wp_next;
  logic [PTR_W-1:0]  rp_next;
  logic              accept;
  logic              full;
  logic              detected;
  logic              done_next;
  logic [63:0]       mask_wide;
  logic [7:0]        poll_start;
  mb_entry_t         mem [MAILBOX_DEPTH];
  mb_entry_t         head;
  mb_entry_t         push_entry;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // clamp the highest polled slave to 1..MAX_SLAVES
  always_comb begin
    eff_highest = highest_slave;
    if (highest_slave == '0) eff_highest = POS_W'(1);
    else if (highest_slave > MAX_POS) eff_highest = MAX_POS;
  end

  // ring pointer arithmetic
  assign wp_next = (write_pointer == PTR_LAST) ? '0 : write_pointer + 1'b1;
  assign rp_next = (read_pointer == PTR_LAST) ? '0 : read_pointer + 1'b1;
  assign full    = (wp_next == read_pointer);

  // detection of the current position, slot 0 always present
  assign mask_wide = {{(64 - MASK_W){1'b0}}, mask[MASK_W-1:1], 1'b1};
  assign detected  = mask_wide[poll.pos];

  // a word comes out after every push and after every decide that issues
  assign done_next = (accept && item.action == ACT_PUSH) ||
                     (state == S_DECIDE &&
                      ((read_pointer != write_pointer) || (poll.pos != '0)));

  // start register picked by the slots
  always_comb begin
    case (poll.msg)
      2'd1:    poll_start = 8'd0;
      2'd2:    poll_start = 8'd2;
      default: poll_start = {4'd0, poll.info, 1'b0} + 8'd2;
    endcase
  end

  // shared position step unit
  bps_advance u_advance (
    .cur         (poll),
    .eff_highest (eff_highest),
    .nxt         (poll_step)
  );

  // new mailbox entry from a push word
  assign push_entry = '{slave: item.cmd_slave, direction: item.cmd_direction,
                        count: item.cmd_count, start: item.cmd_start,
                        word0: item.cmd_word0, word1: item.cmd_word1};

  // mailbox write and registered head read
  always_ff @(posedge clk) begin
    if (accept && item.action == ACT_PUSH && !full) begin
      mem[write_pointer] <= push_entry;
    end
    head <= mem[read_pointer];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      highest_slave       <= POS_W'(50);
      read_direction_code <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIGHEST_SLAVE: highest_slave <= cfg_data[POS_W-1:0];
        REG_READ_DIR:      read_direction_code <= cfg_data;
        default:           ;
      endcase
    end
  end

  // sequencer with pointers, poll state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      write_pointer <= '0;
      read_pointer  <= '0;
      poll          <= '{pos: '0, msg: MSG_FIRST, info: INFO_FIRST};
      done          <= 1'b0;
    end else begin
      done <= done_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.action == ACT_PUSH) begin
              if (full) begin
                result <= '{kind: KIND_FULL, default: '0};
              end else begin
                result        <= '{kind: KIND_PUSH_OK, default: '0};
                write_pointer <= wp_next;
              end
            end else begin
              mask  <= item.detected_mask;
              state <= S_SCAN;
            end
          end
        end
        // one position step a cycle until a detected slave
        S_SCAN: begin
          if (detected) state <= S_DECIDE;
          else poll <= poll_step;
        end
        // mailbox head first, then the poll read
        S_DECIDE: begin
          state <= S_IDLE;
          if (read_pointer != write_pointer) begin
            result       <= '{kind: KIND_ISSUED, out_slave: head.slave,
                              out_direction: head.direction, out_count: head.count,
                              out_start: head.start, out_word0: head.word0,
                              out_word1: head.word1, from_mailbox: 1'b1};
            read_pointer <= rp_next;
            poll         <= poll_step;
          end else if (poll.pos != '0) begin
            result <= '{kind: KIND_ISSUED, out_slave: SLAVE_W'(poll.pos),
                        out_direction: read_direction_code, out_count: POLL_COUNT,
                        out_start: poll_start, out_word0: '0, out_word1: '0,
                        from_mailbox: 1'b0};
            poll   <= poll_step;
          end else begin
            poll.pos <= POS_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result word always lands in an idle cycle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word while busy");

  // a refused push leaves the write pointer alone
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (done && result.kind == KIND_FULL) |-> $stable(write_pointer))
    else $error("write pointer moved on full mailbox");

  // an accepted push moves the write pointer
  a_push_moves: assert property (@(posedge clk) disable iff (rst)
    (done && result.kind == KIND_PUSH_OK) |-> !$stable(write_pointer))
    else $error("push accepted without pointer step");

  // a mailbox send consumes the head entry
  a_send_pops: assert property (@(posedge clk) disable iff (rst)
    (done && result.from_mailbox) |-> !$stable(read_pointer))
    else $error("mailbox send without pointer step");

  // a poll read never addresses slot zero
  a_poll_slave: assert property (@(posedge clk) disable iff (rst)
    (done && result.kind == KIND_ISSUED && !result.from_mailbox)
      |-> result.out_slave != '0)
    else $error("poll read of slot zero");

  // slot counters stay in range
  a_slots: assert property (@(posedge clk) disable iff (rst)
    busy |-> (poll.msg != 2'd0) && (poll.info != 3'd0) && (poll.info <= INFO_LAST))
    else $error("slot counter out of range");

endmodule

// File: tb/bus_poll_scheduler_with_mailbox_checker.sv
// result checker for the bus poll scheduler: tracks mailbox and scan, compares words
module bus_poll_scheduler_with_mailbox_checker
  import bps_pkg::*;
#(
  parameter int MAILBOX_DEPTH = 128,
  parameter int MAX_SLAVES    = 50
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  in_item_t         item,
  input  logic             cfg_we,
  input  reg_index_t       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             done,
  input  out_item_t        result,
  output int               mismatches,
  output int               awaited
);

  // shadow of the mailbox ring, scan position and registers
  mb_entry_t   ring [MAILBOX_DEPTH];
  int unsigned wr_ptr;
  int unsigned rd_ptr;
  int unsigned position;
  int unsigned msg_slot;
  int unsigned info_slot;
  logic [5:0]  highest_reg;
  logic [7:0]  poll_dir;
  out_item_t   awaited_words[$];
  int          errors = 0;

  // register value clamped to the polled range
  function automatic int unsigned highest_polled();
    if (highest_reg == 0) return 1;
    if (highest_reg > MAX_SLAVES) return MAX_SLAVES;
    return highest_reg;
  endfunction

  function automatic bit slave_present(int unsigned pos, logic [MASK_W-1:0] mask);
    if (pos == 0) return 1'b1;
    if (pos >= MASK_W) return 1'b0;
    return mask[pos];
  endfunction

  // start register chosen by the message and info slots
  function automatic logic [7:0] poll_register();
    if (msg_slot == MSG_FIRST) return 8'd0;
    if (msg_slot == 2) return 8'd2;
    return 8'(2 + 2 * info_slot);
  endfunction

  // one step of the poll position, wrapping into the slot counters
  task automatic step_position();
    position++;
    if (position > highest_polled()) begin
      position = 0;
      msg_slot++;
      if (msg_slot > MSG_LAST) begin
        msg_slot = MSG_FIRST;
        info_slot++;
        if (info_slot > INFO_LAST) info_slot = INFO_FIRST;
      end
    end
  endtask

  // apply one accepted word and queue the result it causes, if any
  task automatic scheduler_step(input in_item_t w);
    out_item_t   r;
    int unsigned guard;
    r = '0;
    if (w.action == ACT_PUSH) begin
      if ((wr_ptr + 1) % MAILBOX_DEPTH == rd_ptr) begin
        r.kind = KIND_FULL;
      end else begin
        ring[wr_ptr].slave     = w.cmd_slave;
        ring[wr_ptr].direction = w.cmd_direction;
        ring[wr_ptr].count     = w.cmd_count;
        ring[wr_ptr].start     = w.cmd_start;
        ring[wr_ptr].word0     = w.cmd_word0;
        ring[wr_ptr].word1     = w.cmd_word1;
        wr_ptr = (wr_ptr + 1) % MAILBOX_DEPTH;
        r.kind = KIND_PUSH_OK;
      end
      awaited_words.push_back(r);
    end else begin
      // scan forward to a detected slave
      guard = 0;
      while (!slave_present(position, w.detected_mask) && guard < 200) begin
        guard++;
        step_position();
      end
      if (rd_ptr != wr_ptr) begin
        // mailbox head goes first
        r.kind          = KIND_ISSUED;
        r.out_slave     = ring[rd_ptr].slave;
        r.out_direction = ring[rd_ptr].direction;
        r.out_count     = ring[rd_ptr].count;
        r.out_start     = ring[rd_ptr].start;
        r.out_word0     = ring[rd_ptr].word0;
        r.out_word1     = ring[rd_ptr].word1;
        r.from_mailbox  = 1'b1;
        rd_ptr = (rd_ptr + 1) % MAILBOX_DEPTH;
        step_position();
        awaited_words.push_back(r);
      end else if (position > 0) begin
        // cyclic poll read
        r.kind          = KIND_ISSUED;
        r.out_slave     = 8'(position);
        r.out_direction = poll_dir;
        r.out_count     = POLL_COUNT;
        r.out_start     = poll_register();
        step_position();
        awaited_words.push_back(r);
      end else begin
        position = 1;
      end
    end
  endtask

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    errors++;
  endtask

  // compare results first, then take register writes and new words
  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      wr_ptr      = 0;
      rd_ptr      = 0;
      position    = 0;
      msg_slot    = MSG_FIRST;
      info_slot   = INFO_FIRST;
      highest_reg = 6'd50;
      poll_dir    = 8'd0;
      awaited_words.delete();
    end else begin
      if (done) begin
        if (awaited_words.size() == 0) begin
          $display("%0t: result %h with none expected", $time, result);
          errors++;
        end else begin
          want = awaited_words.pop_front();
          if (result.kind !== want.kind)
            report_field("kind", 16'(want.kind), 16'(result.kind));
          if (result.out_slave !== want.out_slave)
            report_field("out_slave", 16'(want.out_slave), 16'(result.out_slave));
          if (result.out_direction !== want.out_direction)
            report_field("out_direction", 16'(want.out_direction),
                         16'(result.out_direction));
          if (result.out_count !== want.out_count)
            report_field("out_count", 16'(want.out_count), 16'(result.out_count));
          if (result.out_start !== want.out_start)
            report_field("out_start", 16'(want.out_start), 16'(result.out_start));
          if (result.out_word0 !== want.out_word0)
            report_field("out_word0", want.out_word0, result.out_word0);
          if (result.out_word1 !== want.out_word1)
            report_field("out_word1", want.out_word1, result.out_word1);
          if (result.from_mailbox !== want.from_mailbox)
            report_field("from_mailbox", 16'(want.from_mailbox),
                         16'(result.from_mailbox));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_HIGHEST_SLAVE) highest_reg = cfg_data[5:0];
        else poll_dir = cfg_data;
      end
      if (start && !busy) scheduler_step(item);
    end
    mismatches <= errors;
    awaited    <= awaited_words.size();
  end

endmodule

// File: tb/bus_poll_scheduler_with_mailbox_test.sv
// stimulus, watchdog and verdict for the bus poll scheduler
module bus_poll_scheduler_with_mailbox_test;
  import bps_pkg::*;

  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_WORDS   = 220;
  localparam int NUM_PHASES    = 8;

  logic             clk;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  in_item_t         item      = '0;
  logic             cfg_we    = 1'b0;
  reg_index_t       cfg_index = REG_HIGHEST_SLAVE;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             busy;
  logic             done;
  out_item_t        result;
  int               mismatches;
  int               awaited;

  int idle_pct    = 25;
  int words_sent  = 0;
  int stall_count = 0;

  // register settings per phase: highest slave, poll direction
  logic [7:0] phase_highest [NUM_PHASES] = '{8'd50, 8'd0, 8'd3, 8'd255, 8'd1, 8'd12,
                                             8'd63, 8'd7};
  logic [7:0] phase_dir     [NUM_PHASES] = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h3C, 8'h01,
                                             8'h80, 8'hC3};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  bus_poll_scheduler_with_mailbox uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  bus_poll_scheduler_with_mailbox_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .result     (result),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  // watchdog: cycles with no word taken and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("bus_poll_scheduler_with_mailbox_test: FAIL");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // hand one word over, with random gaps ahead of it
  task automatic send_word(input in_item_t w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  // stop sending, wait for every expected word and for idle, then optionally pause
  task automatic settle(input bit full_pause);
    start <= 1'b0;
    @(posedge clk);
    while (awaited != 0 || busy) @(posedge clk);
    if (full_pause) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] highest, input logic [7:0] dir);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HIGHEST_SLAVE;
    cfg_data  <= highest;
    @(posedge clk);
    cfg_index <= REG_READ_DIR;
    cfg_data  <= dir;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic in_item_t make_word(input action_t act, input logic [7:0] slave,
                                         input logic [7:0] dir, input logic [7:0] cnt,
                                         input logic [7:0] reg_start,
                                         input logic [15:0] w0, input logic [15:0] w1,
                                         input logic [MASK_W-1:0] mask);
    in_item_t w;
    w.action        = act;
    w.cmd_slave     = slave;
    w.cmd_direction = dir;
    w.cmd_count     = cnt;
    w.cmd_start     = reg_start;
    w.cmd_word0     = w0;
    w.cmd_word1     = w1;
    w.detected_mask = mask;
    return w;
  endfunction

  // detected masks: random, none, all, one or two slaves, sparse random
  function automatic logic [MASK_W-1:0] make_mask(input int style);
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    case (style)
      0: return bits[MASK_W-1:0];
      1: return '0;
      2: return '1;
      3: begin
        bits = '0;
        bits[$urandom_range(MASK_W-1)] = 1'b1;
        if ($urandom_range(1)) bits[$urandom_range(MASK_W-1)] = 1'b1;
        return bits[MASK_W-1:0];
      end
      default: begin
        bits = bits & {$urandom, $urandom};
        return bits[MASK_W-1:0];
      end
    endcase
  endfunction

  function automatic in_item_t random_word(input action_t act, input int style);
    return make_word(act, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     16'($urandom), 16'($urandom), make_mask(style));
  endfunction

  initial begin : stimulus
    int phase;
    int phase_end;
    int pick;
    int run_len;
    int style;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty mailbox at position zero, polls, pushes, mailbox priority
    send_word(make_word(ACT_NEXT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, '0));
    send_word(make_word(ACT_NEXT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, '1));
    send_word(make_word(ACT_PUSH, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, '0));
    send_word(make_word(ACT_PUSH, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, '1));
    send_word(make_word(ACT_PUSH, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 16'h55AA, 16'hAA55, '0));
    send_word(make_word(ACT_NEXT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, '1));
    send_word(make_word(ACT_NEXT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, '1));
    send_word(make_word(ACT_NEXT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, '0));
    // only the last slave detected, then nothing detected across wraps
    send_word(make_word(ACT_NEXT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                        51'h1 << 50));
    repeat (8)
      send_word(make_word(ACT_NEXT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, '0));
    send_word(make_word(ACT_NEXT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                        51'h2AAAA_AAAA_AAAA));
    settle(1'b1);

    // highest slave of zero with poll direction all ones: wraps on every poll
    write_regs(8'd0, 8'hFF);
    repeat (5)
      send_word(make_word(ACT_NEXT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, '1));

    // random phases, each under its own register setting
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      settle(1'b1);
      write_regs(phase_highest[phase], phase_dir[phase]);
      idle_pct  = (phase < 3) ? 25 : (phase < 6) ? 50 : 0;
      phase_end = words_sent + PHASE_WORDS;
      // some phases open by filling the mailbox past full
      if (phase == 2 || phase == 5)
        repeat (130) send_word(random_word(ACT_PUSH, 0));
      while (words_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          run_len = $urandom_range(30, 4);
          style   = $urandom_range(4);
          repeat (run_len) send_word(random_word(ACT_NEXT, style));
        end else if (pick < 85) begin
          run_len = $urandom_range(20, 4);
          repeat (run_len)
            send_word(random_word($urandom_range(1) ? ACT_NEXT : ACT_PUSH,
                                  $urandom_range(4)));
        end else if (pick < 97) begin
          run_len = $urandom_range(8, 1);
          repeat (run_len) send_word(random_word(ACT_PUSH, 0));
        end else begin
          settle(1'b0);
        end
      end
    end

    settle(1'b1);
    if (awaited != 0) $display("%0t: %0d results never arrived", $time, awaited);
    if (mismatches == 0 && awaited == 0) begin
      $display("bus_poll_scheduler_with_mailbox_test: PASS");
    end else begin
      $display("bus_poll_scheduler_with_mailbox_test: FAIL");
    end
    $finish;
  end

endmodule

// File: bus_poll_scheduler_with_mailbox.f
design/bps_pkg.sv
design/bps_advance.sv
design/bus_poll_scheduler_with_mailbox.sv
tb/bus_poll_scheduler_with_mailbox_checker.sv
tb/bus_poll_scheduler_with_mailbox_test.sv
